// ===== rtl/armik_pkg.sv =====
// Shared types and constants for the planar arm inverse kinematics core.
// Holds the pipeline payload type, register indexes, angle table and gains.
// Depends on nothing.
`default_nettype none

package armik_pkg;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 13;
   localparam int SQ_STEPS = 18;
   localparam int DIV_STEPS = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINK_LENGTH = 2'd0,
      CSR_MIN_REACH   = 2'd1,
      CSR_MAX_REACH   = 2'd2
   } csr_idx_type;

   localparam logic signed [25:0] DEG90  = 26'sd5898240;
   localparam logic signed [25:0] DEG180 = 26'sd11796480;
   localparam logic signed [23:0] BASE_GAIN  = 24'sd3477776;
   localparam logic signed [23:0] JOINT_GAIN = 24'sd3575644;
   localparam logic signed [49:0] BASE_OFS     = 50'sd215 <<< 36;
   localparam logic signed [49:0] SHOULDER_OFS = 50'sd512 <<< 36;
   localparam logic signed [49:0] ELBOW_OFS    = 50'sd525 <<< 36;
   localparam logic signed [49:0] WRIST_OFS    = 50'sd809 <<< 36;

   localparam logic signed [25:0] ATAN [0:23] = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
      26'sd234379, 26'sd117304, 26'sd58666, 26'sd29335,
      26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
      26'sd917, 26'sd458, 26'sd229, 26'sd115,
      26'sd57, 26'sd29, 26'sd14, 26'sd7,
      26'sd4, 26'sd2, 26'sd1, 26'sd0
   };

   typedef struct packed {
      logic                neg_x;
      logic                neg_y;
      logic                x_zero;
      logic                y_zero;
      logic                mir;
      logic                inr;
      logic [13:0]         ax;
      logic [13:0]         ay;
      logic [27:0]         d2;
      logic [35:0]         sq_v;
      logic [19:0]         sq_rem;
      logic [17:0]         sq_root;
      logic signed [35:0]  cx;
      logic signed [35:0]  cy;
      logic signed [25:0]  cz;
      logic signed [26:0]  bdeg;
      logic                d_neg;
      logic                d_ovf;
      logic [28:0]         d_rem;
      logic [16:0]         d_q;
      logic                t_neg;
      logic [16:0]         t_mag;
      logic                s_zero;
   } pl_type;

   function automatic logic signed [35:0] shr_trunc(logic signed [35:0] v, int n);
      logic signed [35:0] m;
      m = -v;
      if (v[35]) begin
         return -(m >>> n);
      end
      return v >>> n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/arm_target_to_servo_positions_core.sv =====
// Top level of the planar arm inverse kinematics core.
// Holds the configuration registers and the full fixed-point pipeline.
// Depends on armik_pkg.
`default_nettype none

// A request carries a target point and a mirror flag and yields one result
// with four servo goal positions. The core is a fixed pipeline that takes a
// new request in every cycle and never asserts busy; each result leaves on
// rsp_strobe in request order, and the receiver cannot stall it. The
// pipeline holds the two 18-step square roots, the 17-step divider and
// the two CORDIC angle units, each of which spends one stage per step.
module arm_target_to_servo_positions_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [13:0]                req_x_pos,
   input  wire logic signed [13:0]                req_y_pos,
   input  wire logic                              req_mirror,
   output logic                                   rsp_strobe,
   output logic                                   rsp_in_range,
   output logic [9:0]                             rsp_base_position,
   output logic [9:0]                             rsp_shoulder_position,
   output logic [9:0]                             rsp_elbow_position,
   output logic [9:0]                             rsp_wrist_position,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [armik_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [armik_pkg::CSR_DATA_W-1:0]  csr_data
);
   import armik_pkg::*;

   localparam int PA = (CORDIC_STEPS > SQ_STEPS) ? CORDIC_STEPS : SQ_STEPS;
   localparam int ST_A0 = 3;
   localparam int ST_D0 = ST_A0 + PA;
   localparam int ST_T = ST_D0 + DIV_STEPS + 1;
   localparam int ST_Q0 = ST_T + 1;
   localparam int ST_C0 = ST_Q0 + SQ_STEPS + 1;
   localparam int ST_F1 = ST_C0 + CORDIC_STEPS + 1;

   logic [10:0] link_ff;
   logic [12:0] min_ff;
   logic [12:0] max_ff;

   pl_type stg_ff [0:ST_F1];
   pl_type stg_in [1:ST_F1];
   pl_type cap_in;
   logic [ST_F1:0] vld_ff;

   logic signed [49:0] bprod_ff, bprod_in;
   logic signed [49:0] jprod_ff, jprod_in;

   logic       strobe_ff;
   logic       inr_ff;
   logic [9:0] base_pos, shoulder_pos, elbow_pos, wrist_pos;

   function automatic pl_type sqrt_step(pl_type p);
      logic [21:0] cur;
      logic [21:0] trial;
      pl_type r;
      r = p;
      cur = {p.sq_rem, p.sq_v[35:34]};
      trial = {2'b00, p.sq_root, 2'b01};
      if (cur >= trial) begin
         r.sq_rem = 20'(cur - trial);
         r.sq_root = {p.sq_root[16:0], 1'b1};
      end else begin
         r.sq_rem = cur[19:0];
         r.sq_root = {p.sq_root[16:0], 1'b0};
      end
      r.sq_v = {p.sq_v[33:0], 2'b00};
      return r;
   endfunction

   function automatic pl_type cordic_step(pl_type p, int i);
      logic signed [35:0] dx;
      logic signed [35:0] dy;
      pl_type r;
      r = p;
      dx = shr_trunc(p.cy, i);
      dy = shr_trunc(p.cx, i);
      if (!p.cy[35]) begin
         r.cx = p.cx + dx;
         r.cy = p.cy - dy;
         r.cz = p.cz + ATAN[5'(i)];
      end else begin
         r.cx = p.cx - dx;
         r.cy = p.cy + dy;
         r.cz = p.cz - ATAN[5'(i)];
      end
      return r;
   endfunction

   function automatic logic [9:0] to_pos(logic signed [49:0] v);
      if (v[49]) begin
         return 10'd0;
      end else if (|v[48:46]) begin
         return 10'd1023;
      end
      return v[45:36];
   endfunction

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= 11'd1600;
         min_ff <= 13'd1600;
         max_ff <= 13'd4800;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LINK_LENGTH: link_ff <= csr_data[10:0];
            CSR_MIN_REACH: min_ff <= csr_data;
            CSR_MAX_REACH: max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cap_in = stg_ff[0];
      cap_in.neg_x = req_x_pos[13];
      cap_in.neg_y = req_y_pos[13];
      cap_in.x_zero = (req_x_pos == 14'sd0);
      cap_in.y_zero = (req_y_pos == 14'sd0);
      cap_in.mir = req_mirror;
      cap_in.ax = req_x_pos[13] ? 14'(-req_x_pos) : req_x_pos;
      cap_in.ay = req_y_pos[13] ? 14'(-req_y_pos) : req_y_pos;
   end

   genvar k;
   generate
      for (k = 1; k <= ST_F1; k++) begin : g_stg
         if (k == 1) begin : g_sq
            always_comb begin
               stg_in[k] = stg_ff[k-1];
               stg_in[k].d2 = 28'(stg_ff[k-1].ax) * 28'(stg_ff[k-1].ax)
                  + 28'(stg_ff[k-1].ay) * 28'(stg_ff[k-1].ay);
            end
         end else if (k == 2) begin : g_init
            logic [25:0] min_sq;
            logic [25:0] max_sq;
            always_comb begin
               min_sq = min_ff * min_ff;
               max_sq = max_ff * max_ff;
               stg_in[k] = stg_ff[k-1];
               stg_in[k].inr = (stg_ff[k-1].d2 >= {2'b00, min_sq})
                  && (stg_ff[k-1].d2 <= {2'b00, max_sq});
               stg_in[k].sq_v = {stg_ff[k-1].d2, 8'd0};
               stg_in[k].sq_rem = '0;
               stg_in[k].sq_root = '0;
               stg_in[k].cx = {6'd0, stg_ff[k-1].ax, 16'd0};
               stg_in[k].cy = {6'd0, stg_ff[k-1].ay, 16'd0};
               stg_in[k].cz = '0;
            end
         end else if (k < ST_D0) begin : g_a
            localparam int I = k - ST_A0;
            always_comb begin
               stg_in[k] = stg_ff[k-1];
               if (I < SQ_STEPS) begin
                  stg_in[k] = sqrt_step(stg_in[k]);
               end
               if (I < CORDIC_STEPS) begin
                  stg_in[k] = cordic_step(stg_in[k], I);
               end
            end
         end else if (k == ST_D0) begin : g_d0
            logic signed [25:0] a;
            logic signed [19:0] num;
            logic [17:0] mag;
            logic [28:0] n;
            always_comb begin
               stg_in[k] = stg_ff[k-1];
               if (stg_ff[k-1].x_zero) begin
                  a = stg_ff[k-1].y_zero ? 26'sd0 : (stg_ff[k-1].neg_y ? -DEG90 : DEG90);
               end else if (stg_ff[k-1].y_zero) begin
                  a = 26'sd0;
               end else begin
                  a = (stg_ff[k-1].neg_x ^ stg_ff[k-1].neg_y) ?
                     -stg_ff[k-1].cz : stg_ff[k-1].cz;
               end
               stg_in[k].bdeg = stg_ff[k-1].mir ? (27'(DEG180) - 27'(a)) : 27'(a);
               num = $signed({2'b00, stg_ff[k-1].sq_root})
                  - $signed({5'd0, link_ff, 4'd0});
               mag = num[19] ? 18'(-num) : num[17:0];
               n = {mag, 11'd0};
               stg_in[k].d_neg = num[19];
               stg_in[k].d_ovf = (n >= {1'b0, link_ff, 17'd0});
               stg_in[k].d_rem = n;
               stg_in[k].d_q = '0;
            end
         end else if (k < ST_T) begin : g_div
            localparam int B = DIV_STEPS - 1 - (k - ST_D0 - 1);
            logic [28:0] divs;
            always_comb begin
               stg_in[k] = stg_ff[k-1];
               divs = 29'(link_ff) << B;
               if (stg_ff[k-1].d_rem >= divs) begin
                  stg_in[k].d_rem = stg_ff[k-1].d_rem - divs;
                  stg_in[k].d_q[B] = 1'b1;
               end
            end
         end else if (k == ST_T) begin : g_t
            logic [16:0] m;
            always_comb begin
               stg_in[k] = stg_ff[k-1];
               if (link_ff == 11'd0) begin
                  m = 17'd65536;
               end else if (stg_ff[k-1].d_ovf || stg_ff[k-1].d_q > 17'd65536) begin
                  m = 17'd65536;
               end else begin
                  m = stg_ff[k-1].d_q;
               end
               stg_in[k].t_mag = m;
               stg_in[k].t_neg = (link_ff != 11'd0) && stg_ff[k-1].d_neg && (m != 17'd0);
               stg_in[k].d2 = 28'd0;
               stg_in[k].sq_v = {2'b00, 34'(m) * 34'(m)};
            end
         end else if (k == ST_Q0) begin : g_q0
            always_comb begin
               stg_in[k] = stg_ff[k-1];
               stg_in[k].sq_v = {3'd0, 33'h1_0000_0000 - stg_ff[k-1].sq_v[32:0]};
               stg_in[k].sq_rem = '0;
               stg_in[k].sq_root = '0;
            end
         end else if (k < ST_C0) begin : g_q
            always_comb begin
               stg_in[k] = sqrt_step(stg_ff[k-1]);
            end
         end else if (k == ST_C0) begin : g_c0
            always_comb begin
               stg_in[k] = stg_ff[k-1];
               stg_in[k].cx = {3'd0, stg_ff[k-1].t_mag, 16'd0};
               stg_in[k].cy = {3'd0, stg_ff[k-1].sq_root[16:0], 16'd0};
               stg_in[k].cz = '0;
               stg_in[k].s_zero = (stg_ff[k-1].sq_root == 18'd0);
            end
         end else if (k < ST_F1) begin : g_c
            localparam int I = k - ST_C0 - 1;
            always_comb begin
               stg_in[k] = cordic_step(stg_ff[k-1], I);
            end
         end else begin : g_f1
            logic signed [25:0] z;
            logic signed [25:0] j;
            always_comb begin
               stg_in[k] = stg_ff[k-1];
               if (stg_ff[k-1].s_zero) begin
                  z = 26'sd0;
               end else if (stg_ff[k-1].t_mag == 17'd0) begin
                  z = DEG90;
               end else begin
                  z = stg_ff[k-1].cz;
               end
               j = stg_ff[k-1].t_neg ? (DEG180 - z) : z;
               stg_in[k].cz = j;
            end
         end
      end
   endgenerate

   always_comb begin
      bprod_in = 50'(stg_ff[ST_F1].bdeg) * 50'(BASE_GAIN) + BASE_OFS;
      jprod_in = 50'(stg_ff[ST_F1].cz) * 50'(JOINT_GAIN);
   end

   always_ff @(posedge clock) begin
      stg_ff[0] <= cap_in;
      for (int i = 1; i <= ST_F1; i++) begin
         stg_ff[i] <= stg_in[i];
      end
      bprod_ff <= bprod_in;
      jprod_ff <= jprod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         vld_ff <= {vld_ff[ST_F1-1:0], start && !busy};
         strobe_ff <= vld_ff[ST_F1];
      end
   end

   always_ff @(posedge clock) begin
      inr_ff <= stg_ff[ST_F1].inr;
   end

   always_comb begin
      if (inr_ff) begin
         base_pos = to_pos(bprod_ff);
         shoulder_pos = to_pos(SHOULDER_OFS - jprod_ff);
         elbow_pos = to_pos(ELBOW_OFS - (jprod_ff <<< 1));
         wrist_pos = to_pos(WRIST_OFS - jprod_ff);
      end else begin
         base_pos = 10'd0;
         shoulder_pos = 10'd0;
         elbow_pos = 10'd0;
         wrist_pos = 10'd0;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_in_range = inr_ff;
   assign rsp_base_position = base_pos;
   assign rsp_shoulder_position = shoulder_pos;
   assign rsp_elbow_position = elbow_pos;
   assign rsp_wrist_position = wrist_pos;

endmodule

`default_nettype wire
